/* src/pwc_pkg.sv */
package pwc_pkg;

  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned WIDTH_W          = 32;
  localparam int unsigned COUNTER_BITS_DEF = 16;

  localparam logic [COUNT_W-1:0] OVF_MAX = 16'hFFFF;

  // Edge the capture unit is waiting for
  typedef enum logic {
    PH_FALL = 1'b0,
    PH_RISE = 1'b1
  } phase_t;

  // One timer event
  typedef struct packed {
    logic               overflow_event;
    logic               capture_event;
    logic [COUNT_W-1:0] captured_count;
    logic [COUNT_W-1:0] current_count;
    logic               result_ack;
  } evt_t;

  // Status after one event
  typedef struct packed {
    logic [WIDTH_W-1:0] pulse_width;
    logic               width_valid;
    logic               width_overwritten;
    logic               expect_rising;
    logic               new_width;
  } res_t;

endpackage

/* src/pulse_width_capture_unit.sv */
// Channel  | Dir | Handshake             | Beat
// ---------+-----+-----------------------+-------------------------------
// evt      | in  | evt_valid / evt_ready | evt_t: one timer event
// res      | out | res_valid / res_ready | res_t: width and flags after it
//
// Every event gives exactly one result beat, via the event and result registers.
// One event per cycle is sustained while res_ready stays high: the event register feeds the state and
// result registers through one 32-bit shift-add-subtract and a compare.
// Reset (rst, synchronous) clears the state: no overflows, waiting for a
// falling edge, no width held, both flags low, both stages empty.
// A stalled result holds in the result register; an empty event register
// can still take one beat, then evt_ready stays low until res_ready returns.
module pulse_width_capture_unit
  import pwc_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_ready,
  input  evt_t evt,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // Counter values narrower than the field are masked to the counter width
  localparam int unsigned        MASK_BITS = (COUNTER_BITS < COUNT_W) ? COUNTER_BITS : COUNT_W;
  localparam logic [COUNT_W-1:0] CNT_MASK  = COUNT_W'((33'd1 << MASK_BITS) - 33'd1);

  // Event register
  logic evt_full;
  evt_t evt_q;

  // Measurement state
  logic [COUNT_W-1:0] overflow_count, overflow_count_next;
  logic [COUNT_W-1:0] start_count, start_count_next;
  phase_t             edge_phase, edge_phase_next;
  logic [WIDTH_W-1:0] width_register, width_register_next;
  logic               valid_flag, valid_flag_next;
  logic               overwrite_flag, overwrite_flag_next;
  logic               done;

  logic advance;

  // Event register moves on when the result register is free or being drained
  assign advance   = evt_full && (!res_valid || res_ready);
  assign evt_ready = !evt_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_full <= 1'b0;
    end else if (evt_ready) begin
      evt_full <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      evt_q <= evt;
    end
  end

  // Datapath for the event in the register
  logic [COUNT_W-1:0] cap, cur, ovf_inc;
  logic               pre_wrap;
  logic [WIDTH_W-1:0] ovf_term;
  logic               valid_acked, overwrite_acked;

  always_comb begin
    cap      = evt_q.captured_count & CNT_MASK;
    cur      = evt_q.current_count & CNT_MASK;
    // A capture value above the serviced count means the edge came before the wrap
    pre_wrap = evt_q.overflow_event && (cap > cur);

    ovf_inc = overflow_count;
    if (evt_q.overflow_event && (overflow_count != OVF_MAX)) begin
      ovf_inc = overflow_count + COUNT_W'(1);
    end

    // Ack lands first, so a width completed in the same event sets valid again
    valid_acked     = valid_flag && !evt_q.result_ack;
    overwrite_acked = overwrite_flag && !evt_q.result_ack;

    overflow_count_next = ovf_inc;
    start_count_next    = start_count;
    width_register_next = width_register;
    valid_flag_next     = valid_acked;
    overwrite_flag_next = overwrite_acked;
    done                = 1'b0;
    ovf_term            = '0;

    if (evt_q.capture_event) begin
      case (edge_phase)
        PH_FALL: begin
          overflow_count_next = pre_wrap ? COUNT_W'(1) : '0;
          start_count_next    = cap;
        end
        PH_RISE: begin
          if (pre_wrap) begin
            overflow_count_next = ovf_inc - COUNT_W'(1);
          end
          // Overflow term wraps at 32 bits, as does the sum
          ovf_term            = WIDTH_W'({16'd0, overflow_count_next} << COUNTER_BITS);
          width_register_next = ovf_term + WIDTH_W'(cap) - WIDTH_W'(start_count);
          if (valid_acked) begin
            overwrite_flag_next = 1'b1;
          end else begin
            valid_flag_next = 1'b1;
          end
          done = 1'b1;
        end
        default: begin
          done = 1'b0;
        end
      endcase
    end
  end

  // Next edge to wait for: toggles on every capture
  always_comb begin
    edge_phase_next = edge_phase;
    if (evt_q.capture_event) begin
      case (edge_phase)
        PH_FALL: edge_phase_next = PH_RISE;
        PH_RISE: edge_phase_next = PH_FALL;
        default: edge_phase_next = PH_FALL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count <= '0;
      start_count    <= '0;
      edge_phase     <= PH_FALL;
      width_register <= '0;
      valid_flag     <= 1'b0;
      overwrite_flag <= 1'b0;
    end else if (advance) begin
      overflow_count <= overflow_count_next;
      start_count    <= start_count_next;
      edge_phase     <= edge_phase_next;
      width_register <= width_register_next;
      valid_flag     <= valid_flag_next;
      overwrite_flag <= overwrite_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.pulse_width       <= width_register_next;
      res.width_valid       <= valid_flag_next;
      res.width_overwritten <= overwrite_flag_next;
      res.expect_rising     <= (edge_phase_next == PH_RISE);
      res.new_width         <= done;
    end
  end

endmodule

/* src/pwc_checker.sv */
module pwc_checker
  import pwc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // Stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // A completed width sends the unit back to waiting for a falling edge
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.new_width |-> !res.expect_rising)
    else $error("width completed but rising edge still expected");

  // Overwrite is only ever raised on top of an unread width
  a_ovw_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.width_overwritten |-> res.width_valid)
    else $error("overwrite flag without valid flag");

  // A completed width is always flagged valid
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.new_width |-> res.width_valid)
    else $error("width completed but not flagged valid");

endmodule

bind pulse_width_capture_unit pwc_checker u_pwc_checker (.*);
